// ----- rtl/alr_pkg.sv -----
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types and constants of the antialiased line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package alr_pkg;

	localparam int CoordW    = 16;          // 12.4 endpoint coordinate
	localparam int FracW     = 4;           // coordinate fraction bits
	localparam int SlopeFrac = 16;          // slope fraction bits
	localparam int SlopeW    = 18;          // signed slope, |slope| <= 1
	localparam int MinorW    = 30;          // signed minor position
	localparam int ColW      = 13;          // pixel column
	localparam int GapW      = 5;           // end gap, 1..16
	localparam int CovW      = 8;           // coverage
	localparam int PixW      = 14;          // signed screen coordinate
	localparam int DvdW      = 33;          // divider dividend
	localparam int CntW      = 6;           // divider step counter

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EP1,
		ST_EP2
	} alr_state_t;

	// which pixel pair goes to the output register
	typedef enum logic [1:0] {
		EM_NONE,
		EM_FIRST,
		EM_END,
		EM_INT
	} alr_emit_t;

	// controller to datapath commands
	typedef struct packed {
		logic      capture;     // latch ordered endpoints, start divide
		logic      slope_load;  // store divider result as slope
		logic      ep1;         // first endpoint setup
		logic      ep2;         // end endpoint setup
		logic      step;        // advance to next interior column
		logic      out_load;    // load output payload register
		alr_emit_t emit_sel;
	} alr_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic end_done;         // no interior columns after the end pair
		logic int_done;         // this interior column is the last
	} alr_status_t;

endpackage

`default_nettype wire

// ----- rtl/alr_div.sv -----
// ----------------------------------------------------------------------------
// alr_div
// Restoring radix-2 divider, one quotient bit per cycle, for the slope.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [alr_pkg::DvdW-1:0]        dividend,
	input  wire logic [alr_pkg::CoordW-1:0]      divisor,
	output logic                                 done,
	output logic [alr_pkg::SlopeFrac:0]          quotient
);

	logic [alr_pkg::DvdW-1:0]   a_q;
	logic [alr_pkg::CoordW-1:0] rem_q;
	logic [alr_pkg::CoordW-1:0] dvs_q;
	logic [alr_pkg::CntW-1:0]   cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [alr_pkg::CoordW:0]   trial;
	logic [alr_pkg::CoordW:0]   diff;
	logic                       ge;

	// one trial subtraction per cycle
	assign trial = {rem_q, a_q[alr_pkg::DvdW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= alr_pkg::CntW'(alr_pkg::DvdW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == alr_pkg::CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift register and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			a_q   <= {a_q[alr_pkg::DvdW-2:0], ge};
			rem_q <= ge ? diff[alr_pkg::CoordW-1:0] : trial[alr_pkg::CoordW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = a_q[alr_pkg::SlopeFrac:0];

endmodule

`default_nettype wire

// ----- rtl/alr_datapath.sv -----
// ----------------------------------------------------------------------------
// alr_datapath
// Endpoint setup, slope, column stepping, coverage and output payload.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_datapath (
	input  wire logic                             clk,
	input  wire logic [alr_pkg::CoordW-1:0]       start_x,
	input  wire logic [alr_pkg::CoordW-1:0]       start_y,
	input  wire logic [alr_pkg::CoordW-1:0]       end_x,
	input  wire logic [alr_pkg::CoordW-1:0]       end_y,
	input  wire alr_pkg::alr_cmd_t                cmd,
	input  wire logic [alr_pkg::SlopeFrac:0]      quotient,
	output logic [alr_pkg::DvdW-1:0]              dividend,
	output logic [alr_pkg::CoordW-1:0]            divisor,
	output alr_pkg::alr_status_t                  status,
	output logic                                  pixel_valid,
	output logic signed [alr_pkg::PixW-1:0]       pixel_x,
	output logic signed [alr_pkg::PixW-1:0]       pixel_y,
	output logic                                  second_along_x,
	output logic [alr_pkg::CovW-1:0]              coverage_first,
	output logic [alr_pkg::CovW-1:0]              coverage_second,
	output logic                                  last
);

	localparam int CW = alr_pkg::CoordW;

	// segment registers
	logic [CW-1:0]                    ax1_q, ay1_q, ax2_q, ay2_q, dx_q;
	logic                             dneg_q, steep_q;
	logic signed [alr_pkg::SlopeW-1:0] slope_q;
	logic signed [alr_pkg::MinorW-1:0] minor_q, end_minor_q;
	logic [alr_pkg::ColW-1:0]          col_q, final_q;
	logic [alr_pkg::GapW-1:0]          gap1_q, end_gap_q;

	// output payload registers
	logic                             pv_q, sax_q, last_q;
	logic [alr_pkg::PixW-1:0]         px_q, py_q;
	logic [alr_pkg::CovW-1:0]         c1_q, c2_q;

	// axis swap and endpoint ordering
	logic [CW-1:0] adx, ady0, sx1, sy1, sx2, sy2, bx1, by1, bx2, by2, cdx, cady;
	logic          steep, swap;
	logic [CW:0]   cdy;

	always_comb begin
		adx   = (end_x > start_x) ? end_x - start_x : start_x - end_x;
		ady0  = (end_y > start_y) ? end_y - start_y : start_y - end_y;
		steep = ady0 > adx;
		sx1   = steep ? start_y : start_x;
		sy1   = steep ? start_x : start_y;
		sx2   = steep ? end_y : end_x;
		sy2   = steep ? end_x : end_y;
		swap  = sx1 > sx2;
		bx1   = swap ? sx2 : sx1;
		by1   = swap ? sy2 : sy1;
		bx2   = swap ? sx1 : sx2;
		by2   = swap ? sy1 : sy2;
		cdx   = bx2 - bx1;
		cdy   = {1'b0, by2} - {1'b0, by1};
		cady  = cdy[CW] ? CW'(-cdy) : cdy[CW-1:0];
	end

	// rounded slope dividend
	assign dividend = {1'b0, cady, {alr_pkg::SlopeFrac{1'b0}}} + alr_pkg::DvdW'(cdx >> 1);
	assign divisor  = cdx;

	// endpoint: minor at the rounded major coordinate
	logic [CW-1:0]                      ep_x, ep_y;
	logic [CW:0]                        xs;
	logic [alr_pkg::ColW-1:0]           ep_col;
	logic signed [CW+2:0]               dwide;
	logic signed [alr_pkg::FracW:0]     dd;
	logic signed [alr_pkg::SlopeW+alr_pkg::FracW:0] prod, prodr;
	logic signed [alr_pkg::MinorW-1:0]  ep_minor;
	logic [alr_pkg::GapW-1:0]           ep_gap;

	always_comb begin
		ep_x     = cmd.ep2 ? ax2_q : ax1_q;
		ep_y     = cmd.ep2 ? ay2_q : ay1_q;
		xs       = {1'b0, ep_x} + (CW+1)'(8);
		ep_col   = xs[CW:alr_pkg::FracW];
		dwide    = $signed({2'b0, ep_col, {alr_pkg::FracW{1'b0}}}) - $signed({3'b0, ep_x});
		dd       = dwide[alr_pkg::FracW:0];
		prod     = slope_q * dd;
		prodr    = (prod + 23'sd8) >>> alr_pkg::FracW;
		ep_minor = $signed({2'b0, ep_y, 12'b0})
		         + alr_pkg::MinorW'(prodr);
		ep_gap   = alr_pkg::GapW'(16) - {1'b0, xs[alr_pkg::FracW-1:0]};
	end

	// column stepping and end tests
	logic [alr_pkg::ColW-1:0] next_col;
	logic [alr_pkg::ColW:0]   col_inc, next_inc;

	assign next_col        = col_q + 1'b1;
	assign col_inc         = {1'b0, col_q} + 1'b1;
	assign next_inc        = {1'b0, next_col} + 1'b1;
	assign status.end_done = {1'b0, final_q} <= col_inc;
	assign status.int_done = next_inc >= {1'b0, final_q};

	// pair select and coverage
	logic [alr_pkg::ColW-1:0]          em_col;
	logic signed [alr_pkg::MinorW-1:0] em_minor;
	logic [alr_pkg::GapW-1:0]          em_gap;
	logic                              em_last;
	logic [alr_pkg::SlopeFrac:0]       fp, rf;
	logic [21:0]                       p1, p2;
	logic [29:0]                       s1, s2;

	always_comb begin
		em_col   = col_q;
		em_minor = minor_q;
		em_gap   = gap1_q;
		em_last  = 1'b0;
		case (cmd.emit_sel)
			alr_pkg::EM_END: begin
				em_col   = final_q;
				em_minor = end_minor_q;
				em_gap   = end_gap_q;
				em_last  = status.end_done;
			end
			alr_pkg::EM_INT: begin
				em_col   = next_col;
				em_gap   = alr_pkg::GapW'(16);
				em_last  = status.int_done;
			end
			default: ;
		endcase
		fp = {1'b0, em_minor[alr_pkg::SlopeFrac-1:0]};
		rf = (alr_pkg::SlopeFrac+1)'(1 << alr_pkg::SlopeFrac) - fp;
		p1 = rf * em_gap;
		p2 = fp * em_gap;
		s1 = ({p1, 8'b0} - 30'(p1)) + 30'(1 << 19);
		s2 = ({p2, 8'b0} - 30'(p2)) + 30'(1 << 19);
	end

	// segment state
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ax1_q   <= bx1;
			ay1_q   <= by1;
			ax2_q   <= bx2;
			ay2_q   <= by2;
			dx_q    <= cdx;
			dneg_q  <= cdy[CW];
			steep_q <= steep;
		end
		if (cmd.slope_load) begin
			if (dx_q == '0)
				slope_q <= alr_pkg::SlopeW'(1 << alr_pkg::SlopeFrac);
			else if (dneg_q)
				slope_q <= -$signed({1'b0, quotient});
			else
				slope_q <= $signed({1'b0, quotient});
		end
		if (cmd.ep1) begin
			minor_q <= ep_minor;
			col_q   <= ep_col;
			gap1_q  <= ep_gap;
		end
		if (cmd.ep2) begin
			end_minor_q <= ep_minor;
			final_q     <= ep_col;
			end_gap_q   <= ep_gap;
			minor_q     <= minor_q + alr_pkg::MinorW'(slope_q);
		end
		if (cmd.step) begin
			col_q   <= next_col;
			minor_q <= minor_q + alr_pkg::MinorW'(slope_q);
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.emit_sel == alr_pkg::EM_NONE) begin
				pv_q   <= 1'b0;
				px_q   <= '0;
				py_q   <= '0;
				sax_q  <= 1'b0;
				c1_q   <= '0;
				c2_q   <= '0;
				last_q <= 1'b0;
			end else begin
				pv_q   <= 1'b1;
				px_q   <= steep_q ? em_minor[29:16] : {1'b0, em_col};
				py_q   <= steep_q ? {1'b0, em_col} : em_minor[29:16];
				sax_q  <= steep_q;
				c1_q   <= s1[27:20];
				c2_q   <= s2[27:20];
				last_q <= em_last;
			end
		end
	end

	assign pixel_valid     = pv_q;
	assign pixel_x         = px_q;
	assign pixel_y         = py_q;
	assign second_along_x  = sax_q;
	assign coverage_first  = c1_q;
	assign coverage_second = c2_q;
	assign last            = last_q;

endmodule

`default_nettype wire

// ----- rtl/alr_ctrl.sv -----
// ----------------------------------------------------------------------------
// alr_ctrl
// Sequencer: handshakes, segment load sequence and line walk state.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 action,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire logic                 div_done,
	input  wire alr_pkg::alr_status_t status,
	output alr_pkg::alr_cmd_t         cmd
);

	alr_pkg::alr_state_t state_q, state_d;
	logic active_q, active_d, phase_q, phase_d, out_valid_q, in_xfer;

	assign in_ready  = (state_q == alr_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= alr_pkg::ST_IDLE;
			active_q    <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			active_q <= active_d;
			phase_q  <= phase_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		active_d = active_q;
		phase_d  = phase_q;
		cmd      = '0;
		cmd.emit_sel = alr_pkg::EM_NONE;
		unique case (state_q)
			alr_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (!action) begin
						cmd.capture = 1'b1;
						active_d    = 1'b1;
						phase_d     = 1'b0;
						state_d     = alr_pkg::ST_DIV;
					end else if (!active_q) begin
						cmd.out_load = 1'b1;
					end else if (!phase_q) begin
						cmd.out_load = 1'b1;
						cmd.emit_sel = alr_pkg::EM_END;
						active_d     = !status.end_done;
						phase_d      = !status.end_done;
					end else begin
						cmd.out_load = 1'b1;
						cmd.step     = 1'b1;
						cmd.emit_sel = alr_pkg::EM_INT;
						if (status.int_done) begin
							active_d = 1'b0;
							phase_d  = 1'b0;
						end
					end
				end
			end
			alr_pkg::ST_DIV: begin
				if (div_done) begin
					cmd.slope_load = 1'b1;
					state_d        = alr_pkg::ST_EP1;
				end
			end
			alr_pkg::ST_EP1: begin
				cmd.ep1 = 1'b1;
				state_d = alr_pkg::ST_EP2;
			end
			alr_pkg::ST_EP2: begin
				cmd.ep2      = 1'b1;
				cmd.out_load = 1'b1;
				cmd.emit_sel = alr_pkg::EM_FIRST;
				state_d      = alr_pkg::ST_IDLE;
			end
			default: state_d = alr_pkg::ST_IDLE;
		endcase
	end

	// checks
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != alr_pkg::ST_IDLE |-> !in_ready)
		else $error("input ready while a load is in progress");
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == alr_pkg::ST_DIV)
		else $error("divider finished outside the divide state");
	a_load_goes_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !action |=> state_q == alr_pkg::ST_DIV && active_q)
		else $error("segment load did not start the divide");
	a_load_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result register loaded but not shown");

endmodule

`default_nettype wire

// ----- rtl/antialiased_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Wu antialiased line generator, one pixel pair per result transfer.
// ----------------------------------------------------------------------------
// an advance transfer gives its result in the next cycle, one per cycle while out_ready
// is high; a load transfer gives the first pair after the 33-step slope divide, the slope
// load and the two endpoint setup states, and the block takes no input meanwhile
// reset clears the sequencer, the line state and the output valid flag
`default_nettype none

module antialiased_line_rasterizer (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic                                   action,
	input  wire logic [alr_pkg::CoordW-1:0]             start_x,
	input  wire logic [alr_pkg::CoordW-1:0]             start_y,
	input  wire logic [alr_pkg::CoordW-1:0]             end_x,
	input  wire logic [alr_pkg::CoordW-1:0]             end_y,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic                                        pixel_valid,
	output logic signed [alr_pkg::PixW-1:0]             pixel_x,
	output logic signed [alr_pkg::PixW-1:0]             pixel_y,
	output logic                                        second_along_x,
	output logic [alr_pkg::CovW-1:0]                    coverage_first,
	output logic [alr_pkg::CovW-1:0]                    coverage_second,
	output logic                                        last
);

	alr_pkg::alr_cmd_t             cmd;
	alr_pkg::alr_status_t          status;
	logic                          div_done;
	logic [alr_pkg::DvdW-1:0]      dividend;
	logic [alr_pkg::CoordW-1:0]    divisor;
	logic [alr_pkg::SlopeFrac:0]   quotient;

	// sequencer
	alr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.div_done  (div_done),
		.status    (status),
		.cmd       (cmd)
	);

	// slope divider
	alr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.capture),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// datapath
	alr_datapath u_dp (
		.clk             (clk),
		.start_x         (start_x),
		.start_y         (start_y),
		.end_x           (end_x),
		.end_y           (end_y),
		.cmd             (cmd),
		.quotient        (quotient),
		.dividend        (dividend),
		.divisor         (divisor),
		.status          (status),
		.pixel_valid     (pixel_valid),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.second_along_x  (second_along_x),
		.coverage_first  (coverage_first),
		.coverage_second (coverage_second),
		.last            (last)
	);

endmodule

`default_nettype wire

// ----- sim/tb_antialiased_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// tb_antialiased_line_rasterizer
// Drives load and advance transfers into the Wu line generator, predicts
// every pixel pair in a scoreboard class and compares each result field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_antialiased_line_rasterizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit ACT_LOAD = 1'b0;
	localparam bit ACT_ADVANCE = 1'b1;
	localparam longint ONE_F = 16;
	localparam longint ONE_S = 65536;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		bit pv;
		bit signed [13:0] px;
		bit signed [13:0] py;
		bit sax;
		bit [7:0] c1;
		bit [7:0] c2;
		bit lst;
	} pair_t;

	// line predictor and queue of expected pixel pairs
	class pair_scoreboard;
		bit running, steep, in_end;
		int unsigned col, fcol, egap;
		longint minor, slope, eminor;
		pair_t pending[$];
		int errors;

		function longint fl_shift(longint v, int sh);
			return v >>> sh;
		endfunction

		function longint endpoint_minor(longint x, longint y, output int unsigned c,
				output int unsigned g);
			longint xr;
			xr = (x + ONE_F / 2) >> 4;
			c = 32'(xr);
			g = 32'(ONE_F - ((x + ONE_F / 2) & (ONE_F - 1)));
			return (y << 12) + fl_shift(slope * ((xr << 4) - x) + ONE_F / 2, 4);
		endfunction

		function pair_t make_pair(int unsigned c, longint m, int unsigned g, bit l);
			pair_t p;
			longint unsigned fp, rf;
			bit [13:0] mi, co;
			fp = m & (ONE_S - 1);
			rf = ONE_S - fp;
			mi = 14'(fl_shift(m, 16));
			co = 14'(c);
			p.pv = 1;
			p.px = steep ? mi : co;
			p.py = steep ? co : mi;
			p.sax = steep;
			p.c1 = 8'((rf * g * 255 + (1 << 19)) >> 20);
			p.c2 = 8'((fp * g * 255 + (1 << 19)) >> 20);
			p.lst = l;
			return p;
		endfunction

		function void note_input(bit act, bit [15:0] sx, bit [15:0] sy,
				bit [15:0] ex, bit [15:0] ey);
			longint x1, y1, x2, y2, t, dx, dy, m1, q;
			int unsigned c1, g1;
			pair_t p;
			bit done;
			if (act == ACT_LOAD) begin
				x1 = sx; y1 = sy; x2 = ex; y2 = ey;
				steep = ((y2 > y1) ? y2 - y1 : y1 - y2) > ((x2 > x1) ? x2 - x1 : x1 - x2);
				if (steep) begin
					t = x1; x1 = y1; y1 = t;
					t = x2; x2 = y2; y2 = t;
				end
				if (x1 > x2) begin
					t = x1; x1 = x2; x2 = t;
					t = y1; y1 = y2; y2 = t;
				end
				dx = x2 - x1;
				dy = y2 - y1;
				if (dx == 0) begin
					slope = ONE_S;
				end else begin
					q = (((dy < 0 ? -dy : dy) << 16) + dx / 2) / dx;
					slope = dy < 0 ? -q : q;
				end
				m1 = endpoint_minor(x1, y1, c1, g1);
				eminor = endpoint_minor(x2, y2, fcol, egap);
				col = c1;
				minor = m1 + slope;
				running = 1;
				in_end = 0;
				p = make_pair(c1, m1, g1, 0);
			end else if (!running) begin
				p = '{default: 0};
			end else if (!in_end) begin
				done = fcol <= col + 1;
				p = make_pair(fcol, eminor, egap, done);
				if (done) running = 0;
				else in_end = 1;
			end else begin
				col = (col + 1) & 13'h1fff;
				done = col + 1 >= fcol;
				p = make_pair(col, minor, 32'(ONE_F), done);
				minor += slope;
				if (done) begin
					running = 0;
					in_end = 0;
				end
			end
			pending.push_back(p);
		endfunction

		function void check_result(pair_t a);
			pair_t e;
			if (pending.size() == 0) begin
				$error("pixel pair with none expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.pv !== e.pv) begin $error("pixel_valid exp %0d got %0d", e.pv, a.pv); errors++; end
			if (a.px !== e.px) begin $error("pixel_x exp %0d got %0d", e.px, a.px); errors++; end
			if (a.py !== e.py) begin $error("pixel_y exp %0d got %0d", e.py, a.py); errors++; end
			if (a.sax !== e.sax) begin
				$error("second_along_x exp %0d got %0d", e.sax, a.sax); errors++;
			end
			if (a.c1 !== e.c1) begin
				$error("coverage_first exp %0d got %0d", e.c1, a.c1); errors++;
			end
			if (a.c2 !== e.c2) begin
				$error("coverage_second exp %0d got %0d", e.c2, a.c2); errors++;
			end
			if (a.lst !== e.lst) begin $error("last exp %0d got %0d", e.lst, a.lst); errors++; end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, action = 0;
	logic [15:0] start_x = 0, start_y = 0, end_x = 0, end_y = 0;
	logic out_valid, out_ready = 0, pixel_valid, second_along_x, last;
	logic signed [13:0] pixel_x, pixel_y;
	logic [7:0] coverage_first, coverage_second;
	bit calm = 0;
	int cycles = 0;
	pair_scoreboard board = new();

	antialiased_line_rasterizer DUT (.*);

	always #5 clk = ~clk;

	// result side: random stalls, check each transfer
	always @(posedge clk) begin
		pair_t r;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			r.pv = pixel_valid; r.px = pixel_x; r.py = pixel_y; r.sax = second_along_x;
			r.c1 = coverage_first; r.c2 = coverage_second; r.lst = last;
			board.check_result(r);
		end
	end

	always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 32);

	// present one item and hold it until transferred
	task automatic send_item(bit act, bit [15:0] sx, bit [15:0] sy, bit [15:0] ex,
			bit [15:0] ey);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; action <= act;
		start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_input(act, sx, sy, ex, ey);
		@(negedge clk);
	endtask

	// short segment around a random point, then advances through it
	task automatic send_line(int span, int advances);
		bit [15:0] x0, y0;
		x0 = 16'($urandom_range(16'hffff - span * 16));
		y0 = 16'($urandom_range(16'hffff - span * 16));
		send_item(ACT_LOAD, x0, y0, 16'(x0 + $urandom_range(span * 16)),
			16'(y0 + $urandom_range(span * 16)));
		repeat (advances)
			send_item(ACT_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
	endtask

	// stop sending and wait for every expected result
	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	initial begin
		int n;
		repeat (8) @(negedge clk);
		arst_n = 1;
		// directed: idle advance, extremes, degenerate, steep, reversed
		send_item(ACT_ADVANCE, 0, 0, 0, 0);
		send_item(ACT_LOAD, 0, 0, 16'hffff, 16'hffff);
		send_item(ACT_ADVANCE, 0, 0, 0, 0);
		send_item(ACT_ADVANCE, 0, 0, 0, 0);
		send_item(ACT_LOAD, 16'h0108, 16'h0208, 16'h0108, 16'h0208);
		send_item(ACT_ADVANCE, 0, 0, 0, 0);
		send_item(ACT_ADVANCE, 0, 0, 0, 0);
		send_item(ACT_LOAD, 16'h0050, 16'h0010, 16'h0013, 16'h0155);
		repeat (5) send_item(ACT_ADVANCE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_item(ACT_LOAD, 16'hfff7, 16'h0003, 16'h0000, 16'hffff);
		send_item(ACT_LOAD, 16'h0207, 16'h0109, 16'h0019, 16'h0201);
		repeat (4) send_item(ACT_ADVANCE, 0, 0, 0, 0);
		send_item(ACT_LOAD, 16'hffff, 16'h0000, 16'h0000, 16'h0000);
		repeat (3) send_item(ACT_ADVANCE, 0, 0, 0, 0);
		drain();
		// random lines; a quiet stretch in the middle
		n = 0;
		while (n < 1330) begin
			int adv;
			calm = (n > 500 && n < 650);
			adv = $urandom_range(12);
			if ($urandom_range(9) == 0) begin
				send_item(ACT_LOAD, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
				repeat (adv)
					send_item(ACT_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom));
			end else begin
				send_line($urandom_range(10) + 1, adv);
			end
			n += adv + 1;
			if ($urandom_range(15) == 0) drain();
		end
		calm = 0;
		drain();
		repeat (50) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

`default_nettype wire

// ----- antialiased_line_rasterizer.f -----
rtl/alr_pkg.sv
rtl/alr_div.sv
rtl/alr_datapath.sv
rtl/alr_ctrl.sv
rtl/antialiased_line_rasterizer.sv
sim/tb_antialiased_line_rasterizer.sv
